// ===== design/sba_pkg.sv =====
package sba_pkg;

   // Field widths of the request, response and capacity register
   localparam int OP_W       = 1;
   localparam int IDX_W      = 9;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 10;
   localparam int CAP_FIELD_W = 10;

   // Bitmap geometry
   localparam int WORD_BITS  = 64;
   localparam int BIT_W      = 6;
   localparam int DEF_MARK_WORDS = 8;
   localparam logic [CAP_FIELD_W-1:0] CAP_RESET = 10'd512;

   // Request opcodes
   localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SLOT     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 2'd2;

endpackage

// ===== design/sba_chan_if.sv =====
interface sba_req_if;
   import sba_pkg::*;

   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  op;
   logic [IDX_W-1:0] slot_index;

   modport source (output valid, op, slot_index, input ready);
   modport sink   (input valid, op, slot_index, output ready);
endinterface

interface sba_rsp_if;
   import sba_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    granted_index;
   logic [COUNT_W-1:0]  used_count;
   logic                is_full;

   modport source (output valid, status, granted_index, used_count, is_full, input ready);
   modport sink   (input valid, status, granted_index, used_count, is_full, output ready);
endinterface

// ===== design/slab_bitmap_slot_allocator_core.sv =====
// Channel  | Ports    | Direction | Payload
// request  | req_if   | in        | op, slot_index
// response | rsp_if   | out       | status, granted_index, used_count, is_full
// config   | csr_*    | in        | slot_capacity (write only)
//
// A free reads and checks its bitmap word; an index past the bitmap skips both.
// An allocate scans the bitmap words in order from word 0, 1 to MARK_WORDS of them,
// as the bitmap memory delivers one 64-bit word per cycle to the lowest-zero unit.
// One request is in flight at a time; the next one is accepted while the
// previous response waits in the output register.
// Reset clears the bitmap through per-word valid bits and the used count; capacity 512.
module slab_bitmap_slot_allocator_core #(
   parameter int MARK_WORDS = sba_pkg::DEF_MARK_WORDS
) (
   input  logic                            clock,
   input  logic                            reset,
   sba_req_if.sink                         req_if,
   sba_rsp_if.source                       rsp_if,
   input  logic                            csr_wr_en,
   input  logic [sba_pkg::CAP_FIELD_W-1:0] csr_wr_data
);
   import sba_pkg::*;

   localparam int TOTAL_SLOTS = MARK_WORDS * WORD_BITS;
   localparam int WORD_W      = (MARK_WORDS > 1) ? $clog2(MARK_WORDS) : 1;
   localparam int SLOT_W      = $clog2(TOTAL_SLOTS);
   localparam int CAP_W       = ($clog2(TOTAL_SLOTS + 1) > CAP_FIELD_W) ?
                                $clog2(TOTAL_SLOTS + 1) : CAP_FIELD_W;
   localparam int NUM_W       = IDX_W - BIT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREE_CHK,
      ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [CAP_FIELD_W-1:0]  cap_ff, cap_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [WORD_W-1:0]       scan_word_ff, scan_word_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic [IDX_W-1:0]        res_granted_ff, res_granted_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]        rsp_granted_ff, rsp_granted_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                    rsp_full_ff, rsp_full_in;

   // Bitmap memory with per-word valid bits
   logic [WORD_BITS-1:0]    mark_mem [MARK_WORDS];
   logic [MARK_WORDS-1:0]   word_valid_ff;
   logic [WORD_BITS-1:0]    rd_data_ff;
   logic                    rd_valid_ff;
   logic                    rd_en;
   logic [WORD_W-1:0]       rd_addr;
   logic                    wr_en;
   logic [WORD_W-1:0]       wr_addr;
   logic [WORD_BITS-1:0]    wr_data;
   logic [WORD_BITS-1:0]    rd_word;

   logic                    zf_found;
   logic [BIT_W-1:0]        zf_bit;
   logic [SLOT_W-1:0]       scan_slot;
   logic [CAP_W-1:0]        eff_cap;
   logic [CAP_W-1:0]        count_ext;
   logic [NUM_W-1:0]        req_word_num;
   logic                    req_in_range;
   logic                    req_fire;
   logic                    rsp_free;
   logic [WORD_W-1:0]       free_word;
   logic [BIT_W-1:0]        free_bit;

   // Clamp the capacity to the bitmap size
   always_comb begin
      if (CAP_W'(cap_ff) < CAP_W'(TOTAL_SLOTS)) begin
         eff_cap = CAP_W'(cap_ff);
      end else begin
         eff_cap = CAP_W'(TOTAL_SLOTS);
      end
   end

   assign count_ext    = CAP_W'(count_ff);
   assign rd_word      = rd_valid_ff ? rd_data_ff : '0;
   assign scan_slot    = SLOT_W'({scan_word_ff, zf_bit});
   assign req_word_num = req_if.slot_index[IDX_W-1:BIT_W];
   assign req_in_range = 32'(req_word_num) < MARK_WORDS;
   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign free_word    = WORD_W'(idx_ff[IDX_W-1:BIT_W]);
   assign free_bit     = idx_ff[BIT_W-1:0];

   sba_zero_find u_zero_find (
      .word    (rd_word),
      .found   (zf_found),
      .bit_idx (zf_bit)
   );

   // Sequencer: next state, memory control and result
   always_comb begin
      state_in       = state_ff;
      cap_in         = csr_wr_en ? csr_wr_data : cap_ff;
      count_in       = count_ff;
      scan_word_in   = scan_word_ff;
      idx_in         = idx_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_full_in    = rsp_full_ff;
      rd_en          = 1'b0;
      rd_addr        = scan_word_ff;
      wr_en          = 1'b0;
      wr_addr        = scan_word_ff;
      wr_data        = rd_word;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in = req_if.slot_index;
               if (req_if.op == OP_ALLOC) begin
                  scan_word_in = '0;
                  rd_en        = 1'b1;
                  rd_addr      = '0;
                  state_in     = ST_SCAN;
               end else if (req_in_range) begin
                  rd_en    = 1'b1;
                  rd_addr  = WORD_W'(req_word_num);
                  state_in = ST_FREE_CHK;
               end else begin
                  res_status_in  = ST_DOUBLE_FREE;
                  res_granted_in = '0;
                  state_in       = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (zf_found) begin
               // Lowest free slot found; grant it if below capacity
               if (CAP_W'(scan_slot) < eff_cap) begin
                  wr_en          = 1'b1;
                  wr_addr        = scan_word_ff;
                  wr_data        = rd_word | (WORD_BITS'(1) << zf_bit);
                  count_in       = count_ff + COUNT_W'(1);
                  res_status_in  = ST_OK;
                  res_granted_in = IDX_W'(scan_slot);
               end else begin
                  res_status_in  = ST_NO_SLOT;
                  res_granted_in = '0;
               end
               state_in = ST_DONE;
            end else if (scan_word_ff == WORD_W'(MARK_WORDS - 1)) begin
               res_status_in  = ST_NO_SLOT;
               res_granted_in = '0;
               state_in       = ST_DONE;
            end else begin
               // Advance to the next word
               scan_word_in = scan_word_ff + WORD_W'(1);
               rd_en        = 1'b1;
               rd_addr      = scan_word_ff + WORD_W'(1);
            end
         end
         ST_FREE_CHK: begin
            res_granted_in = '0;
            if (rd_word[free_bit]) begin
               wr_en         = 1'b1;
               wr_addr       = free_word;
               wr_data       = rd_word & ~(WORD_BITS'(1) << free_bit);
               count_in      = count_ff - COUNT_W'(1);
               res_status_in = ST_OK;
            end else begin
               res_status_in = ST_DOUBLE_FREE;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_granted_in = res_granted_ff;
               rsp_count_in   = count_ff;
               rsp_full_in    = (count_ext == eff_cap);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_word_ff   <= scan_word_in;
      idx_ff         <= idx_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_full_ff    <= rsp_full_in;
   end

   // Word valid bits: cleared at reset, set on first write
   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= '0;
      end else if (wr_en) begin
         word_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Bitmap memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mark_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mark_mem[rd_addr];
         rd_valid_ff <= word_valid_ff[rd_addr];
      end
   end

   assign req_if.ready         = (state_ff == ST_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.granted_index = rsp_granted_ff;
   assign rsp_if.used_count    = rsp_count_ff;
   assign rsp_if.is_full       = rsp_full_ff;

   // An accepted transaction always starts work
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("accepted transaction did not leave idle");

   // The bitmap is written only while checking a word
   a_write_window: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_SCAN || state_ff == ST_FREE_CHK))
      else $error("bitmap written outside scan or free check");

   // Failed transactions grant nothing
   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != ST_OK) |-> rsp_if.granted_index == '0)
      else $error("failed transaction reports a granted slot");

   // The used count never exceeds the bitmap size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ext <= CAP_W'(TOTAL_SLOTS))
      else $error("used count exceeds bitmap size");

endmodule

// ===== design/sba_zero_find.sv =====
module sba_zero_find (
   input  logic [sba_pkg::WORD_BITS-1:0] word,
   output logic                          found,
   output logic [sba_pkg::BIT_W-1:0]     bit_idx
);
   import sba_pkg::*;

   logic [WORD_BITS-1:0] free_bits;

   // Mark free slots with ones
   assign free_bits = ~word;
   assign found     = |free_bits;

   // Binary search for the lowest set bit, halving the window each step
   always_comb begin
      logic [WORD_BITS-1:0] win;
      logic [BIT_W-1:0]     pos;
      logic [WORD_BITS-1:0] low_mask;
      win = free_bits;
      pos = '0;
      for (int k = BIT_W - 1; k >= 0; k--) begin
         low_mask = (WORD_BITS'(1) << (1 << k)) - WORD_BITS'(1);
         if ((win & low_mask) == '0) begin
            pos = pos | BIT_W'(1 << k);
            win = win >> (1 << k);
         end
      end
      bit_idx = pos;
   end
endmodule
